// ===== rtl/core/sqs_pkg.sv =====
`timescale 1ns / 1ps
package sqs_pkg;

    localparam int POS_FRAC_BITS = 8;
    localparam int UV_FRAC_BITS  = 16;
    localparam int ANGLE_BITS    = 16;

    localparam int ANG_RS = (ANGLE_BITS > 16) ? (ANGLE_BITS - 16) : 0;
    localparam int ANG_LS = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;

    // UV datapath
    localparam int UV_W      = UV_FRAC_BITS + 1;
    localparam int NUM_W     = 17 + UV_FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(UV_W + 1);
    localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << UV_FRAC_BITS;

    // position datapath widths
    localparam int CX_W  = 16 + POS_FRAC_BITS;
    localparam int D_W   = CX_W + 2;
    localparam int M_W   = D_W + 16;
    localparam int DX_W  = M_W - 8;
    localparam int PR_W  = DX_W + 17;
    localparam int SUM_W = PR_W + 2;

    localparam int POS_MAX = 8388607;
    localparam int POS_MIN = -8388608;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_TEX_W     = 2'd0,
        CFG_TEX_H     = 2'd1,
        CFG_ORIGIN_BL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [UV_W-1:0]     u0;
        logic [UV_W-1:0]     u1;
        logic [UV_W-1:0]     v0;
        logic [UV_W-1:0]     v1;
        logic [15:0]         w;
        logic [15:0]         h;
        logic signed [23:0]  px;
        logic signed [23:0]  py;
        logic signed [23:0]  ox;
        logic signed [23:0]  oy;
        logic signed [15:0]  scx;
        logic signed [15:0]  scy;
        logic signed [16:0]  sn;
        logic signed [16:0]  cs;
        logic [31:0]         color;
    } t_job;

    // bring the angle to 16 bits of a turn
    function automatic logic [15:0] ang_norm(input logic [15:0] a);
        logic [31:0] v;
        v = 32'(a) & ((32'(1) << ANGLE_BITS) - 32'(1));
        v = (v >> ANG_RS) << ANG_LS;
        return v[15:0];
    endfunction

    // quadrant-folded polynomial argument, Q16 over a quarter turn
    function automatic logic [16:0] trig_t(input logic [15:0] a);
        logic [14:0] r;
        r = {1'b0, a[13:0]};
        if (a[14]) begin
            r = 15'h4000 - r;
        end
        return {r, 2'b00};
    endfunction

    function automatic logic [NUM_W-1:0] uv_num(input logic [16:0] c, input logic [14:0] sz);
        return (NUM_W'(c) << UV_FRAC_BITS) + NUM_W'(sz >> 1);
    endfunction

    function automatic logic signed [23:0] sat_pos(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(POS_MAX)) begin
            return 24'(POS_MAX);
        end else if (v < SUM_W'(POS_MIN)) begin
            return 24'(POS_MIN);
        end
        return v[23:0];
    endfunction

endpackage

// ===== rtl/core/sqs_in_if.sv =====
`timescale 1ns / 1ps
interface sqs_in_if;
    logic        valid;
    logic        ready;
    logic        has_source_rect;
    logic [31:0] src_xy;
    logic [31:0] src_wh;
    logic [47:0] position_xy;
    logic [47:0] origin_xy;
    logic [31:0] scale_xy;
    logic [15:0] angle;
    logic [1:0]  effects;
    logic [31:0] color;

    modport source (
        output valid, has_source_rect, src_xy, src_wh, position_xy, origin_xy,
               scale_xy, angle, effects, color,
        input  ready
    );
    modport sink (
        input  valid, has_source_rect, src_xy, src_wh, position_xy, origin_xy,
               scale_xy, angle, effects, color,
        output ready
    );
endinterface

// ===== rtl/core/sqs_out_if.sv =====
`timescale 1ns / 1ps
interface sqs_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [31:0]        vertex_color;
    logic               last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, tex_u, tex_v, vertex_color, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, tex_u, tex_v, vertex_color, last_vertex,
        output ready
    );
endinterface

// ===== rtl/core/sqs_div.sv =====
`timescale 1ns / 1ps
module sqs_div import sqs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [14:0]      i_den,
    output logic             o_busy,
    output logic [UV_W-1:0]  o_q
);

    logic                 r_busy;
    logic [15:0]          r_rem;
    logic [UV_W-1:0]      r_lo;
    logic [UV_W-1:0]      r_q;
    logic [14:0]          r_den;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [NUM_W-1:0] thr;
    logic [16:0]      rem2;
    logic             qbit;
    logic [16:0]      rem_nx;

    // quotient above one iff num >= (one + 1) * den
    assign thr = (NUM_W'(i_den) << UV_FRAC_BITS) + NUM_W'(i_den);

    always_comb begin
        rem2   = {r_rem, r_lo[UV_W-1]};
        qbit   = (rem2 >= {2'b00, r_den});
        rem_nx = qbit ? (rem2 - {2'b00, r_den}) : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_den <= i_den;
            if (i_num >= thr) begin
                r_q    <= UV_ONE;
                r_busy <= 1'b0;
            end else begin
                r_rem  <= 16'(i_num >> UV_W);
                r_lo   <= i_num[UV_W-1:0];
                r_cnt  <= DIV_CNT_W'(UV_W);
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem  <= rem_nx[15:0];
            r_lo   <= r_lo << 1;
            r_q    <= {r_q[UV_W-2:0], qbit};
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
            r_busy <= (r_cnt != DIV_CNT_W'(1));
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_q;

endmodule

// ===== rtl/core/sqs_front.sv =====
`timescale 1ns / 1ps
module sqs_front import sqs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [14:0] i_tex_w,
    input  logic [14:0] i_tex_h,
    input  logic      i_origin_bl,
    sqs_in_if.sink    i_sprite,
    input  logic      i_q_full,
    output logic      o_push,
    output t_job      o_job
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_X2    = 5'b00010,
        S_INNER = 5'b00100,
        S_POLY  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state;
    t_job   r_job;
    logic   r_rect;
    logic [1:0]  r_eff;
    logic [16:0] r_ts, r_tc;
    logic        r_negs, r_negc;
    logic [16:0] r_x2s, r_x2c;
    logic [15:0] r_ins, r_inc;
    logic [16:0] r_ps, r_pc;

    logic        acc;
    logic [14:0] tw_eff, th_eff;
    logic [15:0] as, ac;
    logic [16:0] sx, sy, sxw, syh;
    logic [NUM_W-1:0] nums [4];
    logic [3:0]       div_busy;
    logic [UV_W-1:0]  div_q [4];

    logic [33:0] sq_s, sq_c;
    logic [29:0] m_s, m_c;
    logic [32:0] pp_s, pp_c;
    logic [33:0] fs, fc;
    logic [17:0] rs, rc;
    logic [UV_W-1:0] u0, u1, v0, v1;

    assign tw_eff = (i_tex_w == 15'd0) ? 15'd1 : i_tex_w;
    assign th_eff = (i_tex_h == 15'd0) ? 15'd1 : i_tex_h;

    assign o_push         = (r_state == S_FIN) && (div_busy == 4'b0000) && !i_q_full;
    assign i_sprite.ready = (r_state == S_IDLE) || o_push;
    assign acc            = i_sprite.valid && i_sprite.ready;

    assign as  = ang_norm(i_sprite.angle);
    assign ac  = as + 16'h4000;
    assign sx  = {1'b0, i_sprite.src_xy[15:0]};
    assign sy  = {1'b0, i_sprite.src_xy[31:16]};
    assign sxw = sx + {1'b0, i_sprite.src_wh[15:0]};
    assign syh = sy + {1'b0, i_sprite.src_wh[31:16]};

    assign nums[0] = uv_num(sx, tw_eff);
    assign nums[1] = uv_num(sxw, tw_eff);
    assign nums[2] = uv_num(sy, th_eff);
    assign nums[3] = uv_num(syh, th_eff);

    for (genvar g = 0; g < 4; g++) begin : g_div
        sqs_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (acc && i_sprite.has_source_rect),
            .i_num   (nums[g]),
            .i_den   ((g < 2) ? tw_eff : th_eff),
            .o_busy  (div_busy[g]),
            .o_q     (div_q[g])
        );
    end

    // sine polynomial steps, sine and cosine side by side
    always_comb begin
        sq_s = 34'(r_ts) * 34'(r_ts);
        sq_c = 34'(r_tc) * 34'(r_tc);
        m_s  = 30'(13'd4640) * 30'(r_x2s);
        m_c  = 30'(13'd4640) * 30'(r_x2c);
        pp_s = 33'(r_x2s) * 33'(r_ins);
        pp_c = 33'(r_x2c) * 33'(r_inc);
        fs   = 34'(r_ts) * 34'(r_ps);
        fc   = 34'(r_tc) * 34'(r_pc);
        rs   = (fs[33:16] + 18'd2) >> 2;
        rc   = (fc[33:16] + 18'd2) >> 2;
    end

    always_comb begin
        u0 = r_rect ? div_q[0] : r_job.u0;
        u1 = r_rect ? div_q[1] : r_job.u1;
        v0 = r_rect ? div_q[2] : r_job.v0;
        v1 = r_rect ? div_q[3] : r_job.v1;
        o_job = r_job;
        o_job.u0 = r_eff[0] ? u1 : u0;
        o_job.u1 = r_eff[0] ? u0 : u1;
        o_job.v0 = r_eff[1] ? v1 : v0;
        o_job.v1 = r_eff[1] ? v0 : v1;
        o_job.sn = r_negs ? -$signed(rs[16:0]) : $signed(rs[16:0]);
        o_job.cs = r_negc ? -$signed(rc[16:0]) : $signed(rc[16:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (acc) r_state <= S_X2;
                S_X2:    r_state <= S_INNER;
                S_INNER: r_state <= S_POLY;
                S_POLY:  r_state <= S_FIN;
                S_FIN: begin
                    if (o_push) begin
                        r_state <= acc ? S_X2 : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rect     <= i_sprite.has_source_rect;
            r_eff      <= i_sprite.effects;
            r_job.w    <= i_sprite.has_source_rect ? i_sprite.src_wh[15:0] : {1'b0, tw_eff};
            r_job.h    <= i_sprite.has_source_rect ? i_sprite.src_wh[31:16] : {1'b0, th_eff};
            r_job.u0   <= '0;
            r_job.u1   <= UV_ONE;
            r_job.v0   <= i_origin_bl ? UV_ONE : '0;
            r_job.v1   <= i_origin_bl ? '0 : UV_ONE;
            r_job.px   <= i_sprite.position_xy[23:0];
            r_job.py   <= i_sprite.position_xy[47:24];
            r_job.ox   <= i_sprite.origin_xy[23:0];
            r_job.oy   <= i_sprite.origin_xy[47:24];
            r_job.scx  <= i_sprite.scale_xy[15:0];
            r_job.scy  <= i_sprite.scale_xy[31:16];
            r_job.sn   <= '0;
            r_job.cs   <= '0;
            r_job.color <= i_sprite.color;
            r_ts       <= trig_t(as);
            r_tc       <= trig_t(ac);
            r_negs     <= as[15];
            r_negc     <= ac[15];
        end
        r_x2s <= sq_s[32:16];
        r_x2c <= sq_c[32:16];
        r_ins <= 16'd42048 - 16'(m_s[29:16]);
        r_inc <= 16'd42048 - 16'(m_c[29:16]);
        r_ps  <= 17'd102944 - pp_s[32:16];
        r_pc  <= 17'd102944 - pp_c[32:16];
    end

endmodule

// ===== rtl/core/sqs_fifo.sv =====
`timescale 1ns / 1ps
module sqs_fifo import sqs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_data
);

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0] r_wp, r_rp;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_IDX_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_IDX_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - FIFO_CNT_W'(1)))
        else $error("queue count did not drop on pop");

endmodule

// ===== rtl/core/sqs_back.sv =====
`timescale 1ns / 1ps
module sqs_back import sqs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_job,
    output logic       o_pop,
    sqs_out_if.source  o_vertex
);

    logic       en, issue;
    logic [1:0] r_k;

    // stage A: scaled corner offsets
    logic                    r_a_valid;
    logic signed [DX_W-1:0]  r_a_dx, r_a_dy;
    logic signed [24:0]      r_a_pox, r_a_poy;
    logic signed [16:0]      r_a_sn, r_a_cs;
    logic [UV_W-1:0]         r_a_u, r_a_v;
    logic [31:0]             r_a_color;
    logic                    r_a_last;

    // stage B: rotation products
    logic                    r_b_valid;
    logic signed [PR_W-1:0]  r_b_cx, r_b_sy, r_b_sx, r_b_cy;
    logic signed [24:0]      r_b_pox, r_b_poy;
    logic [UV_W-1:0]         r_b_u, r_b_v;
    logic [31:0]             r_b_color;
    logic                    r_b_last;

    // output register
    logic                    r_o_valid;
    logic signed [23:0]      r_o_x, r_o_y;
    logic [UV_W-1:0]         r_o_u, r_o_v;
    logic [31:0]             r_o_color;
    logic                    r_o_last;

    logic [CX_W-1:0]         cx, cy;
    logic signed [D_W-1:0]   ddx, ddy;
    logic signed [M_W-1:0]   mx, my;
    logic signed [PR_W:0]    rx, ry;

    assign en    = !r_o_valid || o_vertex.ready;
    assign issue = en && i_valid;
    assign o_pop = issue && (r_k == 2'd3);

    always_comb begin
        cx  = r_k[0] ? (CX_W'(i_job.w) << POS_FRAC_BITS) : '0;
        cy  = r_k[1] ? (CX_W'(i_job.h) << POS_FRAC_BITS) : '0;
        ddx = D_W'($signed({1'b0, cx})) - D_W'(i_job.ox);
        ddy = D_W'($signed({1'b0, cy})) - D_W'(i_job.oy);
        mx  = M_W'(ddx) * M_W'(i_job.scx);
        my  = M_W'(ddy) * M_W'(i_job.scy);
        rx  = ((PR_W+1)'(r_b_cx) - (PR_W+1)'(r_b_sy) + (PR_W+1)'(8192)) >>> 14;
        ry  = ((PR_W+1)'(r_b_sx) + (PR_W+1)'(r_b_cy) + (PR_W+1)'(8192)) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            if (issue) begin
                r_k <= r_k + 2'd1;
            end
            r_a_valid <= issue;
            r_b_valid <= r_a_valid;
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx    <= DX_W'((mx + M_W'(128)) >>> 8);
            r_a_dy    <= DX_W'((my + M_W'(128)) >>> 8);
            r_a_pox   <= 25'(i_job.px) + 25'(i_job.ox);
            r_a_poy   <= 25'(i_job.py) + 25'(i_job.oy);
            r_a_sn    <= i_job.sn;
            r_a_cs    <= i_job.cs;
            r_a_u     <= r_k[0] ? i_job.u1 : i_job.u0;
            r_a_v     <= r_k[1] ? i_job.v1 : i_job.v0;
            r_a_color <= i_job.color;
            r_a_last  <= (r_k == 2'd3);

            r_b_cx    <= PR_W'(r_a_cs) * PR_W'(r_a_dx);
            r_b_sy    <= PR_W'(r_a_sn) * PR_W'(r_a_dy);
            r_b_sx    <= PR_W'(r_a_sn) * PR_W'(r_a_dx);
            r_b_cy    <= PR_W'(r_a_cs) * PR_W'(r_a_dy);
            r_b_pox   <= r_a_pox;
            r_b_poy   <= r_a_poy;
            r_b_u     <= r_a_u;
            r_b_v     <= r_a_v;
            r_b_color <= r_a_color;
            r_b_last  <= r_a_last;

            r_o_x     <= sat_pos(SUM_W'(r_b_pox) + SUM_W'(rx));
            r_o_y     <= sat_pos(SUM_W'(r_b_poy) + SUM_W'(ry));
            r_o_u     <= r_b_u;
            r_o_v     <= r_b_v;
            r_o_color <= r_b_color;
            r_o_last  <= r_b_last;
        end
    end

    assign o_vertex.valid        = r_o_valid;
    assign o_vertex.vertex_x     = r_o_x;
    assign o_vertex.vertex_y     = r_o_y;
    assign o_vertex.tex_u        = 17'(r_o_u);
    assign o_vertex.tex_v        = 17'(r_o_v);
    assign o_vertex.vertex_color = r_o_color;
    assign o_vertex.last_vertex  = r_o_last;

endmodule

// ===== rtl/core/sprite_quad_setup.sv =====
`timescale 1ns / 1ps
// Sprite quad setup: one sprite request in, four vertices out in the order
// top-left, top-right, bottom-left, bottom-right; last_vertex marks the fourth.
// i_sprite is a valid/ready sink, o_vertex a valid/ready source; a transfer
// happens on a clock edge with valid and ready both high.
// Texture size and origin mode are written through i_cfg_we/i_cfg_idx/
// i_cfg_data, by the user only while the block is idle; it is not enforced.
// Throughput: the back end issues one vertex per cycle while the receiver
// is ready, and the front takes a new sprite only when idle or as it pushes
// the previous one into the queue. With a source rectangle, four bit-serial
// dividers compute the UVs, one quotient bit per cycle, and the front holds
// the sprite until they finish; a quotient that saturates at one skips them.
// An accepted sprite passes front states X2, INNER, POLY and FIN, the queue,
// then back stages A, B and the output register before its first vertex.
// A two-entry queue separates the front (trig and UV) from the back (vertex
// transform), so a stalled receiver only backs up the queue before i_sprite
// ready drops. The vertex output register holds its value while stalled.
// Reset clears the pipeline and loads texture size 1x1, top-left origin.
module sprite_quad_setup import sqs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    sqs_in_if.sink      i_sprite,
    sqs_out_if.source   o_vertex
);

    logic [14:0] r_tex_w, r_tex_h;
    logic        r_origin_bl;

    logic q_full, q_valid, push, pop;
    t_job push_job, head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w     <= 15'd1;
            r_tex_h     <= 15'd1;
            r_origin_bl <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEX_W:     r_tex_w     <= i_cfg_data;
                CFG_TEX_H:     r_tex_h     <= i_cfg_data;
                CFG_ORIGIN_BL: r_origin_bl <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sqs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tex_w     (r_tex_w),
        .i_tex_h     (r_tex_h),
        .i_origin_bl (r_origin_bl),
        .i_sprite    (i_sprite),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    sqs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_job)
    );

    sqs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_vertex (o_vertex)
    );

endmodule
